[rtl/bpss_pkg.sv]
// shared types and constants of the bass pattern step sequencer
package bpss_pkg;

  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;

  // register indexes of the configuration port
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;
  localparam logic [1:0] REG_LENGTH = 2'd2;
  localparam logic [1:0] REG_MASK   = 2'd3;

  // pattern codes
  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_DRIVE    = 3'd1,
    MODE_BOUNCE   = 3'd2,
    MODE_SYNC     = 3'd3,
    MODE_PUMP     = 3'd4,
    MODE_STACCATO = 3'd5,
    MODE_USER     = 3'd6,
    MODE_RESERVED = 3'd7
  } mode_t;

  // user step lengths
  localparam logic [2:0] LEN_SIXTEENTH = 3'd4;
  localparam logic [2:0] LEN_THIRTYSEC = 3'd5;

  typedef enum logic [1:0] {
    KIND_STATUS   = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_NOTE_OFF = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             item_kind;
    logic              suppress_input;
    logic [NOTE_W-1:0] event_note;
    logic [VEL_W-1:0]  event_velocity;
    logic              last_of_block;
  } res_t;

endpackage

[rtl/bpss_in_if.sv]
// input channel of the bass pattern step sequencer: one audio block per beat
interface bpss_in_if #(
  parameter int FRACTION_BITS = 16
);
  logic                            valid;
  logic                            ready;
  logic                            has_note_on;
  logic [bpss_pkg::NOTE_W-1:0]     incoming_note;
  logic                            transport_playing;
  logic [32+FRACTION_BITS-1:0]     beat_position;

  modport source (
    output valid, has_note_on, incoming_note, transport_playing, beat_position,
    input  ready
  );

  modport sink (
    input  valid, has_note_on, incoming_note, transport_playing, beat_position,
    output ready
  );
endinterface

[rtl/bpss_out_if.sv]
// result channel of the bass pattern step sequencer: status and note events
interface bpss_out_if;
  logic                        valid;
  logic                        ready;
  bpss_pkg::kind_t             item_kind;
  logic                        suppress_input;
  logic [bpss_pkg::NOTE_W-1:0] event_note;
  logic [bpss_pkg::VEL_W-1:0]  event_velocity;
  logic                        last_of_block;

  modport source (
    output valid, item_kind, suppress_input, event_note, event_velocity, last_of_block,
    input  ready
  );

  modport sink (
    input  valid, item_kind, suppress_input, event_note, event_velocity, last_of_block,
    output ready
  );
endinterface

[rtl/bass_pattern_step_sequencer.sv]
// bass pattern step sequencer top level: pattern decode, step tracking and result queue
//
//   channel   direction  handshake              payload
//   in_ch     in         valid/ready            has_note_on, incoming_note,
//                                               transport_playing, beat_position
//   out_ch    out        valid/ready            item_kind, suppress_input, event_note,
//                                               event_velocity, last_of_block
//   apb       in/out     psel/penable, pready=1 pattern_enable, pattern_mode,
//                                               user_step_length, user_step_mask
//
// an input beat is evaluated in the cycle it is taken and its one to three result
// beats are written into a four-entry result queue at once; the output drains one
// beat per cycle while out_ch.ready is high. in_ch.ready is high while at most one
// result waits, so an input beat can be taken every cycle while each block yields
// one result and out_ch does not stall; the single output port paces note events.
// rst_n is synchronous: it clears the queue, the tracked note and step state and
// the registers to enable 0, mode off, step length sixteenth, mask all ones.
module bass_pattern_step_sequencer #(
  parameter int USER_STEPS    = 16,
  parameter int FRACTION_BITS = 16,
  localparam int DATA_W = (USER_STEPS > 32) ? 64 : 32,
  localparam int ADDR_W = (DATA_W == 64) ? 5 : 4
) (
  input  logic              clk,
  input  logic              rst_n,
  bpss_in_if.sink           in_ch,
  bpss_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // widths of the datapath
  localparam int POS_W   = 32 + FRACTION_BITS;
  localparam int STEP_W  = 35;                       // pos >> (FRACTION_BITS-3) at most
  localparam int SH_W    = $clog2(FRACTION_BITS + 3);
  localparam int FR_W    = FRACTION_BITS + 2;        // widest in-step fraction
  localparam int CMP_W   = 16 + FR_W;
  localparam int IDX_W   = $clog2(USER_STEPS);

  // step modulo USER_STEPS: 6-bit digits weighted by 2^(6j) mod USER_STEPS, then
  // one reciprocal multiply on the small sum
  localparam int DIG_W   = 6;
  localparam int DIGITS  = (STEP_W + DIG_W - 1) / DIG_W;
  localparam int EXT_W   = DIGITS * DIG_W;
  localparam int TERM_W  = 2 * DIG_W;
  localparam int RES_W   = TERM_W + 3;
  localparam int RECIP_S = RES_W + 6;
  localparam int PROD_W  = RES_W + RECIP_S;
  localparam longint unsigned RECIP_M =
    ((64'd1 << RECIP_S) + USER_STEPS - 1) / USER_STEPS;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // gate thresholds, Q0.16 rounded up
  localparam logic [15:0] GATE_90 = 16'd58983;
  localparam logic [15:0] GATE_80 = 16'd52429;
  localparam logic [15:0] GATE_70 = 16'd45876;
  localparam logic [15:0] GATE_60 = 16'd39322;
  localparam logic [15:0] GATE_50 = 16'd32768;
  localparam logic [15:0] GATE_30 = 16'd19661;

  localparam logic [6:0] VEL_FULL   = 7'd127;
  localparam logic [6:0] VEL_90     = 7'd114;
  localparam logic [6:0] VEL_85     = 7'd107;
  localparam logic [6:0] VEL_80     = 7'd101;
  localparam logic [6:0] VEL_70     = 7'd88;
  localparam logic [6:0] VEL_60     = 7'd76;
  localparam logic [6:0] VEL_50     = 7'd63;
  localparam logic [6:0] VEL_NONE   = 7'd0;
  localparam logic [7:0] OCTAVE     = 8'd12;
  localparam logic [6:0] NOTE_MAX   = 7'd127;

  // configuration registers
  logic                  en_r;
  logic [2:0]            mode_r;
  logic [2:0]            len_r;
  logic [USER_STEPS-1:0] mask_r;

  // tracked state
  logic [6:0]            held_note_r;
  logic                  held_valid_r;
  logic [STEP_W-1:0]     prev_step_r;
  logic                  prev_valid_r;
  logic                  sounding_r;

  // result queue
  bpss_pkg::res_t        q_r [QDEPTH];
  logic [QPTR_W-1:0]     head_r;
  logic [QCNT_W-1:0]     cnt_r;
  logic [QCNT_W-1:0]     cnt_nxt;

  logic                  in_fire;
  logic                  out_fire;
  logic                  cfg_wr;
  logic [1:0]            reg_idx;

  logic                  active;
  logic [6:0]            held_note_nxt;
  logic                  held_valid_nxt;
  logic                  suppress;
  logic                  mode_known;
  logic                  evaluate;
  logic [SH_W-1:0]       shift;
  logic [POS_W-1:0]      pos;
  logic [STEP_W-1:0]     step;
  logic [FR_W-1:0]       frac_mask;
  logic [FR_W-1:0]       frac;
  logic [2:0]            bi_idx;
  logic [EXT_W-1:0]      step_ext;
  logic [TERM_W-1:0]     dig_term [DIGITS];
  logic [RES_W-1:0]      res_sum;
  logic [PROD_W-1:0]     recip_prod;
  logic [RES_W-1:0]      quot;
  logic [RES_W-1:0]      rem;
  logic [IDX_W-1:0]      user_idx;
  logic [6:0]            vel;
  logic [15:0]           gate;
  logic                  odd_oct;
  logic [7:0]            note_sum;
  logic [6:0]            note;
  logic                  new_step;
  logic                  fire_on;
  logic                  sounding_mid;
  logic [CMP_W-1:0]      frac_lhs;
  logic [CMP_W-1:0]      gate_rhs;
  logic                  fire_off;
  bpss_pkg::res_t        res_status;
  bpss_pkg::res_t        res_on;
  bpss_pkg::res_t        res_off;
  bpss_pkg::res_t        res_slot [3];
  logic [1:0]            push_n;
  logic [QPTR_W-1:0]     tail;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // ---------------------------------------------------------------------------
  // apb register file, zero wait states
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      mode_r <= bpss_pkg::MODE_OFF;
      len_r  <= bpss_pkg::LEN_SIXTEENTH;
      mask_r <= '1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bpss_pkg::REG_ENABLE: en_r   <= pwdata[0];
        bpss_pkg::REG_MODE:   mode_r <= pwdata[2:0];
        bpss_pkg::REG_LENGTH: len_r  <= pwdata[2:0];
        bpss_pkg::REG_MASK:   mask_r <= pwdata[USER_STEPS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bpss_pkg::REG_ENABLE: prdata = DATA_W'(en_r);
      bpss_pkg::REG_MODE:   prdata = DATA_W'(mode_r);
      bpss_pkg::REG_LENGTH: prdata = DATA_W'(len_r);
      bpss_pkg::REG_MASK:   prdata = DATA_W'(mask_r);
    endcase
  end

  // ---------------------------------------------------------------------------
  // note tracking and suppression
  // ---------------------------------------------------------------------------
  assign active         = en_r && (mode_r != bpss_pkg::MODE_OFF);
  assign held_note_nxt  = (active && in_ch.has_note_on) ? in_ch.incoming_note : held_note_r;
  assign held_valid_nxt = held_valid_r || (active && in_ch.has_note_on);
  assign suppress       = active && held_valid_nxt && in_ch.transport_playing;

  // step length as a right shift of the beat position
  always_comb begin
    mode_known = 1'b1;
    shift      = SH_W'(FRACTION_BITS - 2);
    case (mode_r)
      bpss_pkg::MODE_DRIVE, bpss_pkg::MODE_BOUNCE, bpss_pkg::MODE_PUMP: begin
        shift = SH_W'(FRACTION_BITS - 1);
      end
      bpss_pkg::MODE_SYNC, bpss_pkg::MODE_STACCATO: shift = SH_W'(FRACTION_BITS - 2);
      bpss_pkg::MODE_USER: begin
        if (len_r <= bpss_pkg::LEN_THIRTYSEC) begin
          shift = SH_W'(FRACTION_BITS + 2) - SH_W'(len_r);
        end else begin
          shift = SH_W'(FRACTION_BITS - 2);
        end
      end
      default: mode_known = 1'b0;   // off and reserved pattern codes: status only
    endcase
  end

  assign evaluate  = suppress && mode_known;
  assign pos       = in_ch.beat_position;
  assign step      = STEP_W'(pos >> shift);
  assign frac_mask = (FR_W'(1) << shift) - FR_W'(1);
  assign frac      = pos[FR_W-1:0] & frac_mask;
  assign bi_idx    = step[2:0];

  // user step index: step mod USER_STEPS
  assign step_ext = EXT_W'(step);

  for (genvar j = 0; j < DIGITS; j++) begin : g_dig
    localparam longint unsigned WGT = (64'd1 << (DIG_W * j)) % USER_STEPS;
    assign dig_term[j] = TERM_W'(step_ext[DIG_W*j +: DIG_W]) * TERM_W'(WGT);
  end

  always_comb begin
    res_sum = '0;
    for (int j = 0; j < DIGITS; j++) begin
      res_sum = res_sum + RES_W'(dig_term[j]);
    end
  end

  assign recip_prod = PROD_W'(res_sum) * PROD_W'(RECIP_M);
  assign quot       = recip_prod[PROD_W-1:RECIP_S];
  assign rem        = res_sum - RES_W'(quot * RES_W'(USER_STEPS));
  assign user_idx   = rem[IDX_W-1:0];

  // pattern tables: velocity, gate and octave of the current step
  always_comb begin
    vel     = VEL_NONE;
    gate    = GATE_90;
    odd_oct = 1'b0;
    case (mode_r)
      bpss_pkg::MODE_DRIVE: begin
        vel  = bi_idx[0] ? VEL_80 : VEL_FULL;
        gate = GATE_80;
      end
      bpss_pkg::MODE_BOUNCE: begin
        vel     = VEL_90;
        gate    = GATE_70;
        odd_oct = bi_idx[0];
      end
      bpss_pkg::MODE_SYNC: begin
        if (bi_idx[1:0] == 2'd0) begin
          vel = VEL_FULL;
        end else if (!bi_idx[0]) begin
          vel = VEL_70;
        end else begin
          vel = VEL_50;
        end
        gate = GATE_50;
      end
      bpss_pkg::MODE_PUMP: begin
        vel  = bi_idx[0] ? VEL_60 : VEL_FULL;
        gate = bi_idx[0] ? GATE_60 : GATE_90;
      end
      bpss_pkg::MODE_STACCATO: begin
        vel  = VEL_85;
        gate = GATE_30;
      end
      bpss_pkg::MODE_USER: begin
        vel  = mask_r[user_idx] ? VEL_80 : VEL_NONE;
        gate = GATE_90;
      end
      default: begin
        vel  = VEL_NONE;
        gate = GATE_90;
      end
    endcase
  end

  // octave offset with saturation at the top note
  assign note_sum = {1'b0, held_note_nxt} + (odd_oct ? OCTAVE : 8'd0);
  assign note     = note_sum[7] ? NOTE_MAX : note_sum[6:0];

  // note-on on a fresh step, note-off once the fraction reaches the gate
  assign new_step     = evaluate && (!prev_valid_r || (step != prev_step_r));
  assign fire_on      = new_step && (vel != VEL_NONE);
  assign sounding_mid = sounding_r || fire_on;
  assign frac_lhs     = {frac, 16'd0};
  assign gate_rhs     = CMP_W'(gate) << shift;
  assign fire_off     = evaluate && sounding_mid && (frac_lhs >= gate_rhs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_note_r  <= '0;
      held_valid_r <= 1'b0;
      prev_step_r  <= '0;
      prev_valid_r <= 1'b0;
      sounding_r   <= 1'b0;
    end else if (in_fire) begin
      held_note_r  <= held_note_nxt;
      held_valid_r <= held_valid_nxt;
      if (new_step) begin
        prev_step_r  <= step;
        prev_valid_r <= 1'b1;
      end
      sounding_r <= sounding_mid && !fire_off;
    end
  end

  // ---------------------------------------------------------------------------
  // result beats of one block, in order: status, note-on, note-off
  // ---------------------------------------------------------------------------
  always_comb begin
    res_status.item_kind      = bpss_pkg::KIND_STATUS;
    res_status.suppress_input = suppress;
    res_status.event_note     = '0;
    res_status.event_velocity = '0;
    res_status.last_of_block  = !(fire_on || fire_off);

    res_on.item_kind          = bpss_pkg::KIND_NOTE_ON;
    res_on.suppress_input     = 1'b0;
    res_on.event_note         = note;
    res_on.event_velocity     = vel;
    res_on.last_of_block      = !fire_off;

    res_off.item_kind         = bpss_pkg::KIND_NOTE_OFF;
    res_off.suppress_input    = 1'b0;
    res_off.event_note        = note;
    res_off.event_velocity    = '0;
    res_off.last_of_block     = 1'b1;

    res_slot[0] = res_status;
    res_slot[1] = fire_on ? res_on : res_off;
    res_slot[2] = res_off;
  end

  assign push_n = 2'd1 + 2'(fire_on) + 2'(fire_off);
  assign tail   = head_r + cnt_r[QPTR_W-1:0];

  // queue: room for a full block whenever at most one beat waits
  assign in_ch.ready = (cnt_r <= QCNT_W'(1));
  assign cnt_nxt     = cnt_r + (in_fire ? QCNT_W'(push_n) : '0) - QCNT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (out_fire) begin
        head_r <= head_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < push_n) begin
          q_r[tail + QPTR_W'(k)] <= res_slot[k];
        end
      end
    end
  end

  assign out_ch.valid          = (cnt_r != '0);
  assign out_ch.item_kind      = q_r[head_r].item_kind;
  assign out_ch.suppress_input = q_r[head_r].suppress_input;
  assign out_ch.event_note     = q_r[head_r].event_note;
  assign out_ch.event_velocity = q_r[head_r].event_velocity;
  assign out_ch.last_of_block  = q_r[head_r].last_of_block;

endmodule

[rtl/bpss_checker.sv]
// port-level checks of the bass pattern step sequencer and their binding
module bpss_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input bpss_pkg::kind_t             out_kind,
  input logic                        out_suppress,
  input logic [bpss_pkg::NOTE_W-1:0] out_note,
  input logic [bpss_pkg::VEL_W-1:0]  out_vel,
  input logic                        out_last
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_note) &&
      $stable(out_vel) && $stable(out_suppress) && $stable(out_last))
    else $error("result payload changed while stalled");

  // input only stalls behind waiting results
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // fields fit the kind of beat
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == bpss_pkg::KIND_STATUS && out_note == '0 && out_vel == '0) ||
      (out_kind == bpss_pkg::KIND_NOTE_ON && !out_suppress && out_vel != '0) ||
      (out_kind == bpss_pkg::KIND_NOTE_OFF && !out_suppress && out_vel == '0))
    else $error("result fields do not match item kind");

  // the rest of a block follows at once and is never a status beat
  a_block_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_kind != bpss_pkg::KIND_STATUS)
    else $error("block continued with a status beat or a gap");

endmodule

bind bass_pattern_step_sequencer bpss_checker u_bpss_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.item_kind),
  .out_suppress (out_ch.suppress_input),
  .out_note     (out_ch.event_note),
  .out_vel      (out_ch.event_velocity),
  .out_last     (out_ch.last_of_block)
);
